FILE: src/afk_pkg.sv
// Shared constants, types and helper functions for the arm forward kinematics core.
`timescale 1ns / 1ps
package afk_pkg;

  // Field widths.
  localparam int ANG_W   = 18;
  localparam int SUM_W   = 20;
  localparam int LEN_W   = 16;
  localparam int PX_W    = 19;
  localparam int PZ_W    = 20;
  localparam int REG_IDX_W = 2;

  // Angle reduction: an offset of twenty quarter turns makes every chain sum positive.
  localparam int QUARTER_TURN = 23040;
  localparam logic [SUM_W-1:0] ANGLE_OFFSET = 20'd460800;
  localparam logic [11:0] RECIP_45 = 12'd2913;

  // CORDIC datapath.
  localparam int CORDIC_STEPS = 20;
  localparam int XY_W = 33;
  localparam int Z_W  = 25;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

  // Front end latency: three reduction stages, CORDIC steps, quadrant fold.
  localparam int FRONT_LAT = 3 + CORDIC_STEPS + 1;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_BASE_HEIGHT     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PROXIMAL_LENGTH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DISTAL_LENGTH   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_HOLDER_LENGTH   = 2'd3;

  typedef logic signed [XY_W-1:0] trig_t;

  // Arctangent of 2^-i in Q.16 degrees, rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_deg(input int i);
    logic signed [Z_W-1:0] a;
    unique case (i)
      0:  a = 25'sd2949120;
      1:  a = 25'sd1740967;
      2:  a = 25'sd919879;
      3:  a = 25'sd466945;
      4:  a = 25'sd234379;
      5:  a = 25'sd117304;
      6:  a = 25'sd58666;
      7:  a = 25'sd29335;
      8:  a = 25'sd14668;
      9:  a = 25'sd7334;
      10: a = 25'sd3667;
      11: a = 25'sd1833;
      12: a = 25'sd917;
      13: a = 25'sd458;
      14: a = 25'sd229;
      15: a = 25'sd115;
      16: a = 25'sd57;
      17: a = 25'sd29;
      18: a = 25'sd14;
      default: a = 25'sd7;
    endcase
    return a;
  endfunction

  // Clamp a rounded planar coordinate to the 19-bit output range.
  function automatic logic signed [PX_W-1:0] sat_xy(input logic signed [25:0] v);
    logic signed [PX_W-1:0] r;
    if (v > 26'sd262143) begin
      r = 19'sd262143;
    end else if (v < -26'sd262144) begin
      r = -19'sd262144;
    end else begin
      r = v[PX_W-1:0];
    end
    return r;
  endfunction

  // Clamp the vertical position to the 20-bit output range.
  function automatic logic signed [PZ_W-1:0] sat_z(input logic signed [23:0] v);
    logic signed [PZ_W-1:0] r;
    if (v > 24'sd524287) begin
      r = 20'sd524287;
    end else if (v < -24'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = v[PZ_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/afk_angle_reduce.sv
// Three-stage reduction of a Q12.8 degree angle to a quadrant and a CORDIC residue.
`timescale 1ns / 1ps
module afk_angle_reduce (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic signed [afk_pkg::SUM_W-1:0]     in_angle,
  output logic                                 out_valid,
  output logic [1:0]                           out_quad,
  output logic signed [afk_pkg::Z_W-1:0]       out_z
);
  import afk_pkg::*;

  logic [2:0]        valid_r;
  logic [SUM_W-1:0]  val1_r;
  logic [SUM_W-1:0]  val2_r;
  logic [5:0]        qcnt_r;
  logic [22:0]       recip_prod;
  logic [SUM_W-1:0]  resid_full;
  logic [1:0]        quad_r;
  logic [14:0]       resid_r;

  // Quarter-turn count: divide by 512 with a shift, then by 45 with a reciprocal.
  assign recip_prod = 23'(val1_r[SUM_W-1:9]) * 23'(RECIP_45);
  assign resid_full = val2_r - SUM_W'(qcnt_r * 20'(QUARTER_TURN));

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[1:0], in_valid};
    end
  end

  // Payload stages: offset, quarter count, residue and quadrant.
  always_ff @(posedge clk) begin
    val1_r  <= SUM_W'(in_angle + $signed(ANGLE_OFFSET));
    val2_r  <= val1_r;
    qcnt_r  <= recip_prod[22:17];
    quad_r  <= qcnt_r[1:0];
    resid_r <= resid_full[14:0];
  end

  assign out_valid = valid_r[2];
  assign out_quad  = quad_r;
  assign out_z     = $signed({2'b00, resid_r, 8'b0});

endmodule

FILE: src/afk_cordic.sv
// Pipelined rotation-mode CORDIC in degree units with a quadrant fold at the output.
`timescale 1ns / 1ps
module afk_cordic (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [1:0]                       in_quad,
  input  logic signed [afk_pkg::Z_W-1:0]   in_z,
  output logic                             out_valid,
  output afk_pkg::trig_t                   out_cos,
  output afk_pkg::trig_t                   out_sin
);
  import afk_pkg::*;

  trig_t                 x_r [CORDIC_STEPS];
  trig_t                 y_r [CORDIC_STEPS];
  logic signed [Z_W-1:0] z_r [CORDIC_STEPS];
  logic [1:0]            q_r [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0] v_r;

  trig_t                 x_in [CORDIC_STEPS];
  trig_t                 y_in [CORDIC_STEPS];
  logic signed [Z_W-1:0] z_in [CORDIC_STEPS];
  logic [1:0]            q_in [CORDIC_STEPS];
  trig_t                 x_nxt [CORDIC_STEPS];
  trig_t                 y_nxt [CORDIC_STEPS];
  logic signed [Z_W-1:0] z_nxt [CORDIC_STEPS];

  logic                  ov_r;
  trig_t                 cos_r;
  trig_t                 sin_r;

  // One micro-rotation per stage; stage zero starts from the gain on the x axis.
  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        x_in[i] = CORDIC_GAIN;
        y_in[i] = '0;
        z_in[i] = in_z;
        q_in[i] = in_quad;
      end else begin
        x_in[i] = x_r[i-1];
        y_in[i] = y_r[i-1];
        z_in[i] = z_r[i-1];
        q_in[i] = q_r[i-1];
      end
      if (z_in[i] >= 0) begin
        x_nxt[i] = x_in[i] - (y_in[i] >>> i);
        y_nxt[i] = y_in[i] + (x_in[i] >>> i);
        z_nxt[i] = z_in[i] - atan_deg(i);
      end else begin
        x_nxt[i] = x_in[i] + (y_in[i] >>> i);
        y_nxt[i] = y_in[i] - (x_in[i] >>> i);
        z_nxt[i] = z_in[i] + atan_deg(i);
      end
    end
  end

  // Valid bits for the rotation stages and the fold stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      v_r  <= {v_r[CORDIC_STEPS-2:0], in_valid};
      ov_r <= v_r[CORDIC_STEPS-1];
    end
  end

  // Rotation stage registers.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      x_r[i] <= x_nxt[i];
      y_r[i] <= y_nxt[i];
      z_r[i] <= z_nxt[i];
      q_r[i] <= q_in[i];
    end
  end

  // Map the first-quadrant result back to the full circle.
  always_ff @(posedge clk) begin
    unique case (q_r[CORDIC_STEPS-1])
      2'd0: begin
        cos_r <= x_r[CORDIC_STEPS-1];
        sin_r <= y_r[CORDIC_STEPS-1];
      end
      2'd1: begin
        cos_r <= -y_r[CORDIC_STEPS-1];
        sin_r <= x_r[CORDIC_STEPS-1];
      end
      2'd2: begin
        cos_r <= -x_r[CORDIC_STEPS-1];
        sin_r <= -y_r[CORDIC_STEPS-1];
      end
      default: begin
        cos_r <= y_r[CORDIC_STEPS-1];
        sin_r <= -x_r[CORDIC_STEPS-1];
      end
    endcase
  end

  assign out_valid = ov_r;
  assign out_cos   = cos_r;
  assign out_sin   = sin_r;

endmodule

FILE: src/afk_combine.sv
// Four-stage multiply and accumulate that turns link angles into the end position.
`timescale 1ns / 1ps
module afk_combine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  afk_pkg::trig_t                       c1,
  input  afk_pkg::trig_t                       s1,
  input  afk_pkg::trig_t                       c2,
  input  afk_pkg::trig_t                       s2,
  input  afk_pkg::trig_t                       c3,
  input  afk_pkg::trig_t                       s3,
  input  afk_pkg::trig_t                       cy,
  input  afk_pkg::trig_t                       sy,
  input  logic [afk_pkg::LEN_W-1:0]            extension,
  input  logic [afk_pkg::LEN_W-1:0]            base_height,
  input  logic [afk_pkg::LEN_W-1:0]            proximal_length,
  input  logic [afk_pkg::LEN_W-1:0]            distal_length,
  input  logic [afk_pkg::LEN_W-1:0]            holder_length,
  output logic                                 out_valid,
  output logic signed [afk_pkg::PX_W-1:0]      pos_x,
  output logic signed [afk_pkg::PX_W-1:0]      pos_y,
  output logic signed [afk_pkg::PZ_W-1:0]      pos_z
);
  import afk_pkg::*;

  localparam int PW = 51;
  localparam int SW = 53;
  localparam int HW = 34;
  localparam int VW = 23;
  localparam int MW = 70;

  logic [3:0]               v_r;
  logic signed [LEN_W:0]    l1s;
  logic signed [LEN_W:0]    l2s;
  logic signed [LEN_W+1:0]  l3s;

  logic signed [PW-1:0]     pc1_r, pc2_r, pc3_r, ps1_r, ps2_r, ps3_r;
  trig_t                    cy1_r, sy1_r, cy2_r, sy2_r;
  logic signed [SW-1:0]     hsum;
  logic signed [SW-1:0]     vsum;
  logic signed [HW-1:0]     h_r;
  logic signed [VW-1:0]     vrnd;
  logic signed [23:0]       pz_r;
  logic signed [MW-1:0]     hx_r, hy_r;
  logic signed [PZ_W-1:0]   pzs_r;
  logic signed [PX_W-1:0]   px_r, py_r;
  logic signed [PZ_W-1:0]   pzo_r;
  logic signed [MW-1:0]     rx, ry;

  assign l1s = $signed({1'b0, proximal_length});
  assign l2s = $signed({1'b0, distal_length});
  assign l3s = $signed({1'b0, 17'({1'b0, holder_length} + {1'b0, extension})});

  // Valid bits for the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  // Stage one: link length times cosine and sine.
  always_ff @(posedge clk) begin
    pc1_r <= l1s * c1;
    pc2_r <= l2s * c2;
    pc3_r <= l3s * c3;
    ps1_r <= l1s * s1;
    ps2_r <= l2s * s2;
    ps3_r <= l3s * s3;
    cy1_r <= cy;
    sy1_r <= sy;
  end

  // Stage two: sum the links, round the reach to Q14 and the height to whole units.
  assign hsum = SW'(pc1_r) + SW'(pc2_r) + SW'(pc3_r);
  assign vsum = SW'(ps1_r) + SW'(ps2_r) + SW'(ps3_r);
  assign vrnd = VW'((vsum + (53'sd1 <<< 29)) >>> 30);

  always_ff @(posedge clk) begin
    h_r   <= HW'((hsum + 53'sd32768) >>> 16);
    pz_r  <= $signed({8'b0, base_height}) + 24'(vrnd);
    cy2_r <= cy1_r;
    sy2_r <= sy1_r;
  end

  // Stage three: rotate the reach by the yaw, clamp the height.
  always_ff @(posedge clk) begin
    hx_r  <= h_r * cy2_r;
    hy_r  <= h_r * sy2_r;
    pzs_r <= sat_z(pz_r);
  end

  // Stage four: round the planar products and clamp them.
  assign rx = (hx_r + (70'sd1 <<< 43)) >>> 44;
  assign ry = (hy_r + (70'sd1 <<< 43)) >>> 44;

  always_ff @(posedge clk) begin
    px_r  <= sat_xy(rx[25:0]);
    py_r  <= sat_xy(ry[25:0]);
    pzo_r <= pzs_r;
  end

  assign out_valid = v_r[3];
  assign pos_x     = px_r;
  assign pos_y     = py_r;
  assign pos_z     = pzo_r;

endmodule

FILE: src/arm_forward_kinematics_core.sv
// Top level of the arm forward kinematics core: configuration, angle chain and pipeline.
//
//   Channel   Ports                                   Handshake
//   request   start, busy, in_*                       taken when start & !busy
//   result    out_valid, out_pos_x/y/z                one-cycle strobe, no stall
//   config    cfg_we, cfg_index, cfg_wdata            written when cfg_we is high
//
// A new request is taken every cycle; busy is always low. Each result passes
// through three angle reduction stages, twenty CORDIC steps, one quadrant fold
// and four multiply-accumulate stages. Reset clears the valid bits and the length
// registers. The result side cannot stall, so no request is held back.
`timescale 1ns / 1ps
module arm_forward_kinematics_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [afk_pkg::ANG_W-1:0]      in_base_yaw,
  input  logic signed [afk_pkg::ANG_W-1:0]      in_shoulder_pitch,
  input  logic signed [afk_pkg::ANG_W-1:0]      in_elbow_pitch,
  input  logic signed [afk_pkg::ANG_W-1:0]      in_wrist_pitch,
  input  logic [afk_pkg::LEN_W-1:0]             in_extension,
  output logic                                  out_valid,
  output logic signed [afk_pkg::PX_W-1:0]       out_pos_x,
  output logic signed [afk_pkg::PX_W-1:0]       out_pos_y,
  output logic signed [afk_pkg::PZ_W-1:0]       out_pos_z,
  input  logic                                  cfg_we,
  input  logic [afk_pkg::REG_IDX_W-1:0]         cfg_index,
  input  logic [afk_pkg::LEN_W-1:0]             cfg_wdata
);
  import afk_pkg::*;

  logic [LEN_W-1:0]        base_height_r;
  logic [LEN_W-1:0]        proximal_length_r;
  logic [LEN_W-1:0]        distal_length_r;
  logic [LEN_W-1:0]        holder_length_r;

  logic                    req;
  logic signed [SUM_W-1:0] ang [4];
  logic                    rv [4];
  logic [1:0]              rq [4];
  logic signed [Z_W-1:0]   rz [4];
  logic                    cv [4];
  trig_t                   cc [4];
  trig_t                   cs [4];
  logic [LEN_W-1:0]        ext_r [FRONT_LAT];

  assign busy = 1'b0;
  assign req  = start & ~busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_height_r     <= '0;
      proximal_length_r <= '0;
      distal_length_r   <= '0;
      holder_length_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_HEIGHT:     base_height_r     <= cfg_wdata;
        REG_PROXIMAL_LENGTH: proximal_length_r <= cfg_wdata;
        REG_DISTAL_LENGTH:   distal_length_r   <= cfg_wdata;
        default:             holder_length_r   <= cfg_wdata;
      endcase
    end
  end

  // Pitch angles accumulate along the chain; lane three carries the yaw.
  assign ang[0] = SUM_W'(in_shoulder_pitch);
  assign ang[1] = ang[0] + SUM_W'(in_elbow_pitch);
  assign ang[2] = ang[1] + SUM_W'(in_wrist_pitch);
  assign ang[3] = SUM_W'(in_base_yaw);

  // One reduction and CORDIC lane per angle.
  for (genvar g = 0; g < 4; g++) begin : g_lane
    afk_angle_reduce u_reduce (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (req),
      .in_angle  (ang[g]),
      .out_valid (rv[g]),
      .out_quad  (rq[g]),
      .out_z     (rz[g])
    );

    afk_cordic u_cordic (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (rv[g]),
      .in_quad   (rq[g]),
      .in_z      (rz[g]),
      .out_valid (cv[g]),
      .out_cos   (cc[g]),
      .out_sin   (cs[g])
    );
  end

  // Extension follows the angle lanes through the front end.
  always_ff @(posedge clk) begin
    ext_r[0] <= in_extension;
    for (int i = 1; i < FRONT_LAT; i++) begin
      ext_r[i] <= ext_r[i-1];
    end
  end

  afk_combine u_combine (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (cv[0]),
    .c1              (cc[0]),
    .s1              (cs[0]),
    .c2              (cc[1]),
    .s2              (cs[1]),
    .c3              (cc[2]),
    .s3              (cs[2]),
    .cy              (cc[3]),
    .sy              (cs[3]),
    .extension       (ext_r[FRONT_LAT-1]),
    .base_height     (base_height_r),
    .proximal_length (proximal_length_r),
    .distal_length   (distal_length_r),
    .holder_length   (holder_length_r),
    .out_valid       (out_valid),
    .pos_x           (out_pos_x),
    .pos_y           (out_pos_y),
    .pos_z           (out_pos_z)
  );

endmodule
